// File: design/brbq_pkg.sv
`default_nettype none
package brbq_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AMT_W   = 12;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned GAP     = 1;
  localparam int unsigned IN_TW   = 24;
  localparam int unsigned OUT_TW  = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_DROP = 3'd3,
    CMD_ADV  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic             accepted;
    logic             rd_sel;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } res_t;

endpackage
`default_nettype wire

// File: design/byte_ring_buffer_queue.sv
`default_nettype none
// Circular byte queue of DEPTH bytes (one slot always kept free) taking one
// command per input word: push, pop, peek at an offset, drop n, advance the
// write index by n. Each command returns exactly one result word carrying
// the byte read, the accept flag, the count moved and the used and free
// counts after the command. After acceptance a command passes through the
// synchronous byte store read and then the output register before its
// result appears; the next word is taken only when no command is pending
// and the output register is free or being drained, so words never overlap.
// The byte store is not cleared at reset; reading a slot never written
// returns an undefined byte.
module byte_ring_buffer_queue
  import brbq_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [10:3] data_in, [22:11] amount, [23] zero
  input  wire logic [IN_TW-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [7:0] data_out, [8] accepted, [20:9] moved, [32:21] used_count,
  // [44:33] free_count, [47:45] zero
  output logic      [OUT_TW-1:0] out_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              pend_r;
  logic              out_valid_r;
  logic [OUT_TW-1:0] out_data_r;
  res_t              res, res_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata, dout;

  assign in_tready = !pend_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  brbq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_tdata[2:0]),
    .data_in   (in_tdata[10:3]),
    .amount    (in_tdata[22:11]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  brbq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign dout = res_r.rd_sel ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= accept;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_data_r <= {3'b000, res_r.free_count, res_r.used_count, res_r.moved,
                     res_r.accepted, dout};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: design/brbq_mem.sv
`default_nettype none
module brbq_mem
  import brbq_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/brbq_ctrl.sv
`default_nettype none
module brbq_ctrl
  import brbq_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [BYTE_W-1:0] data_in,
  input  wire logic [AMT_W-1:0]  amount,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [BYTE_W-1:0] mem_wdata,
  output logic                   mem_re,
  output logic      [AW-1:0]     mem_raddr,
  output res_t                   res
);

  localparam int unsigned CW  = ((AW > AMT_W) ? AW : AMT_W) + 1;
  localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_W   = CW'(DEPTH - GAP);
  localparam logic [CW-1:0] ONE_W   = CW'(1);

  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] used_r;
  logic [CW-1:0] used_w, free_w, amt_w, clamp_w, used_nxt, moved_w;
  logic [AW-1:0] rd_inc, wr_inc, rd_amt, wr_clamp;
  logic          acc, rd_sel;
  cmd_t          cmd_c;

  function automatic logic [AW-1:0] wrap(input logic [CW-1:0] x);
    logic [CW-1:0] y;
    y = (x >= DEPTH_W) ? (x - DEPTH_W) : x;
    return y[AW-1:0];
  endfunction

  assign cmd_c   = cmd_t'(cmd);
  assign used_w  = CW'(used_r);
  assign free_w  = CAP_W - used_w;
  assign amt_w   = CW'(amount);
  assign clamp_w = (amt_w < free_w) ? amt_w : free_w;

  assign rd_inc   = wrap(CW'(rd_r) + ONE_W);
  assign wr_inc   = wrap(CW'(wr_r) + ONE_W);
  assign rd_amt   = wrap(CW'(rd_r) + amt_w);
  assign wr_clamp = wrap(CW'(wr_r) + clamp_w);

  always_comb begin
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    used_nxt  = used_w;
    moved_w   = '0;
    acc       = 1'b0;
    rd_sel    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wr_r;
    mem_raddr = rd_r;
    unique case (cmd_c)
      CMD_PUSH: begin
        if (free_w != '0) begin
          mem_we   = accept;
          wr_nxt   = wr_inc;
          used_nxt = used_w + ONE_W;
          moved_w  = ONE_W;
          acc      = 1'b1;
        end
      end
      CMD_POP: begin
        if (used_w != '0) begin
          mem_re   = accept;
          rd_nxt   = rd_inc;
          used_nxt = used_w - ONE_W;
          moved_w  = ONE_W;
          acc      = 1'b1;
          rd_sel   = 1'b1;
        end
      end
      CMD_PEEK: begin
        mem_raddr = rd_amt;
        if (amt_w < used_w) begin
          mem_re = accept;
          acc    = 1'b1;
          rd_sel = 1'b1;
        end
      end
      CMD_DROP: begin
        if (amt_w <= used_w) begin
          rd_nxt   = rd_amt;
          used_nxt = used_w - amt_w;
          moved_w  = amt_w;
          acc      = 1'b1;
        end
      end
      CMD_ADV: begin
        wr_nxt   = wr_clamp;
        used_nxt = used_w + clamp_w;
        moved_w  = clamp_w;
        acc      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mem_wdata = data_in;

  always_comb begin
    logic [CW-1:0] free_nxt;
    free_nxt       = CAP_W - used_nxt;
    res.accepted   = acc;
    res.rd_sel     = rd_sel;
    res.moved      = moved_w[CNT_W-1:0];
    res.used_count = used_nxt[CNT_W-1:0];
    res.free_count = free_nxt[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r   <= '0;
      wr_r   <= '0;
      used_r <= '0;
    end else if (accept) begin
      rd_r   <= rd_nxt;
      wr_r   <= wr_nxt;
      used_r <= used_nxt[AW-1:0];
    end
  end

endmodule
`default_nettype wire
